// File: hw/rtl/batch_vehicle_kinematics_step_defines.svh
// Assertion macros for the vehicle kinematics block.
`ifndef BATCH_VEHICLE_KINEMATICS_STEP_DEFINES_SVH
`define BATCH_VEHICLE_KINEMATICS_STEP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define BVK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bvk check failed");

// Next-cycle implication checked outside reset.
`define BVK_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bvk check failed");

`endif

// File: hw/rtl/bvk_pkg.sv
package bvk_pkg;
  localparam int NumAgents = 64;
  localparam int FracBits = 16;
  localparam int IdxW = 6;
  localparam int CntW = 7;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_STEP = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_MAX_H     = 3'd1;
  localparam logic [2:0] REG_MAX_V     = 3'd2;
  localparam logic [2:0] REG_IDLE      = 3'd3;
  localparam logic [2:0] REG_SPEED     = 3'd4;
  localparam logic [2:0] REG_WIND_E    = 3'd5;
  localparam logic [2:0] REG_WIND_N    = 3'd6;
  localparam logic [2:0] REG_ACTIVE    = 3'd7;

  localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

  typedef struct packed {
    logic rd;       // issue read of entry at addr
    logic wr_load;  // write load payload
    logic wr_cmd;   // write command payload
    logic out_read; // present read result
    logic [IdxW-1:0] addr;
  } bvk_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // floor shift of a product by FracBits
  function automatic logic signed [47:0] mulq_shift(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FracBits;
    return s[47:0];
  endfunction
endpackage

// File: hw/rtl/bvk_ctrl.sv
module bvk_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [1:0] in_opcode,
  input  logic [bvk_pkg::IdxW-1:0] in_agent_index,
  input  logic [bvk_pkg::CntW-1:0] active_count,
  output logic busy,
  output bvk_pkg::bvk_cmd_t cmd
);
  import bvk_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt, lim;
  logic [3:0] drain_r, drain_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic go;

  assign go = start && (state_r == ST_IDLE);
  assign busy = state_r != ST_IDLE;
  assign lim = (active_count > CntW'(NumAgents)) ? CntW'(NumAgents) : active_count;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    drain_nxt = drain_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.addr = in_agent_index;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          unique case (in_opcode)
            OP_LOAD: cmd.wr_load = 1'b1;
            OP_CMD:  cmd.wr_cmd = 1'b1;
            OP_READ: begin
              cmd.rd = 1'b1;
              idx_nxt = in_agent_index;
              state_nxt = ST_READ;
            end
            default: begin
              cnt_nxt = '0;
              state_nxt = ST_STEP;
            end
          endcase
        end
      end
      ST_STEP: begin
        if (cnt_r < lim) begin
          cmd.rd = 1'b1;
          cmd.addr = cnt_r[IdxW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          drain_nxt = 4'd3;
          state_nxt = ST_DRAIN;
        end
      end
      ST_READ: begin
        cmd.out_read = 1'b1;
        cmd.addr = idx_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        if (drain_r == 4'd0) state_nxt = ST_IDLE;
        else drain_nxt = drain_r - 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      drain_r <= '0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      drain_r <= drain_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule

// File: hw/rtl/bvk_datapath.sv
module bvk_datapath (
  input  logic clk,
  input  logic rst_n,
  input  bvk_pkg::bvk_cmd_t cmd,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [30:0] in_fuel_load,
  input  logic [30:0] in_elapsed_load,
  input  logic [30:0] time_step,
  input  logic [30:0] max_step_horizontal,
  input  logic [30:0] max_step_vertical,
  input  logic [30:0] idle_burn_rate,
  input  logic [30:0] speed_burn_rate,
  input  logic signed [31:0] wind_east,
  input  logic signed [31:0] wind_north,
  output logic out_valid,
  output logic [bvk_pkg::IdxW-1:0] out_index,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [30:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic [30:0] out_fuel,
  output logic [30:0] out_elapsed
);
  import bvk_pkg::*;

  typedef struct packed {
    logic signed [31:0] px, py;
    logic [30:0] pz;
    logic signed [31:0] vx, vy, vz;
    logic [30:0] fuel, el;
  } ent_t;

  typedef struct packed {
    logic signed [31:0] x, y, z;
  } vec_t;

  ent_t mem_ent [NumAgents];
  vec_t mem_cmd [NumAgents];
  logic [NumAgents-1:0] cmd_vld_r;

  ent_t rd_ent_r;
  vec_t rd_cmd_r;
  logic rd_cmd_ok_r;
  logic s1_r;
  logic [IdxW-1:0] s1_addr_r;

  // stage 1 read
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_ent_r <= mem_ent[cmd.addr];
      rd_cmd_r <= mem_cmd[cmd.addr];
    end
    rd_cmd_ok_r <= cmd_vld_r[cmd.addr];
    s1_addr_r <= cmd.addr;
  end

  vec_t cmdv;
  assign cmdv = rd_cmd_ok_r ? rd_cmd_r : '0;

  // stage 2: slew velocity, add wind
  function automatic logic signed [31:0] slew(input logic signed [31:0] v,
                                              input logic signed [31:0] c,
                                              input logic [30:0] lim);
    logic signed [33:0] d, l, r;
    d = 34'(c) - 34'(v);
    l = 34'(signed'({1'b0, lim}));
    if (d > l) r = l;
    else if (d < -l) r = -l;
    else r = d;
    return sat32(34'(v) + r);
  endfunction

  logic signed [31:0] vx2, vy2, vz2;
  logic signed [31:0] vx2_r, vy2_r, vz2_r, gx_r, gy_r;
  ent_t e2_r;
  logic s2_r;
  logic [IdxW-1:0] a2_r;
  assign vx2 = slew(rd_ent_r.vx, cmdv.x, max_step_horizontal);
  assign vy2 = slew(rd_ent_r.vy, cmdv.y, max_step_horizontal);
  assign vz2 = slew(rd_ent_r.vz, cmdv.z, max_step_vertical);

  always_ff @(posedge clk) begin
    vx2_r <= vx2;
    vy2_r <= vy2;
    vz2_r <= vz2;
    gx_r <= sat32(34'(vx2) + 34'(wind_east));
    gy_r <= sat32(34'(vy2) + 34'(wind_north));
    e2_r <= rd_ent_r;
    a2_r <= s1_addr_r;
  end

  // stage 3: multiply by time step, L1 speed with and without the vertical term
  logic signed [63:0] pxm, pym, pzm;
  logic signed [47:0] dx_r, dy_r, dz_r;
  logic [33:0] spd;
  logic [32:0] spd_xy;
  logic [30:0] spd_r, spd_xy_r;
  logic signed [31:0] vx3_r, vy3_r, vz3_r;
  ent_t e3_r;
  logic s3_r;
  logic [IdxW-1:0] a3_r;
  logic signed [32:0] ts_s;
  assign ts_s = 33'(signed'({2'b0, time_step}));
  assign pxm = 64'(gx_r) * 64'(ts_s);
  assign pym = 64'(gy_r) * 64'(ts_s);
  assign pzm = 64'(vz2_r) * 64'(ts_s);
  function automatic logic [31:0] absv(input logic signed [31:0] v);
    return v[31] ? 32'(-33'(v)) : 32'(v);
  endfunction
  assign spd = 34'(absv(vx2_r)) + 34'(absv(vy2_r)) + 34'(absv(vz2_r));
  assign spd_xy = 33'(absv(vx2_r)) + 33'(absv(vy2_r));

  always_ff @(posedge clk) begin
    dx_r <= mulq_shift(pxm);
    dy_r <= mulq_shift(pym);
    dz_r <= mulq_shift(pzm);
    spd_r <= (spd > 34'h7fffffff) ? 31'h7fffffff : spd[30:0];
    spd_xy_r <= (spd_xy > 33'h7fffffff) ? 31'h7fffffff : spd_xy[30:0];
    vx3_r <= vx2_r;
    vy3_r <= vy2_r;
    vz3_r <= vz2_r;
    e3_r <= e2_r;
    a3_r <= a2_r;
  end

  // stage 4: positions, burn rate (vertical speed drops out on ground contact)
  logic [61:0] rm, rm_xy;
  logic [46:0] rsum, rsum_xy;
  logic [30:0] rate_r;
  logic signed [47:0] nx, ny, nz;
  ent_t e4_r;
  logic s4_r;
  logic [IdxW-1:0] a4_r;
  assign rm = 62'(speed_burn_rate) * 62'(spd_r);
  assign rsum = 47'(idle_burn_rate) + 47'(rm >> FracBits);
  assign rm_xy = 62'(speed_burn_rate) * 62'(spd_xy_r);
  assign rsum_xy = 47'(idle_burn_rate) + 47'(rm_xy >> FracBits);
  assign nx = 48'(e3_r.px) + dx_r;
  assign ny = 48'(e3_r.py) + dy_r;
  assign nz = 48'(signed'({1'b0, e3_r.pz})) + dz_r;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh7fffffff) r = 32'sh7fffffff;
    else if (v < -48'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [30:0] rate_sat(input logic [46:0] v);
    return (v > 47'h7fffffff) ? 31'h7fffffff : v[30:0];
  endfunction

  logic signed [31:0] zs;
  logic gnd;
  assign zs = sat48(nz);
  assign gnd = zs[31] && vz3_r[31];
  always_ff @(posedge clk) begin
    e4_r.px <= sat48(nx);
    e4_r.py <= sat48(ny);
    e4_r.pz <= zs[31] ? 31'd0 : zs[30:0];
    e4_r.vx <= vx3_r;
    e4_r.vy <= vy3_r;
    e4_r.vz <= gnd ? 32'sd0 : vz3_r;
    e4_r.fuel <= e3_r.fuel;
    e4_r.el <= e3_r.el;
    rate_r <= gnd ? rate_sat(rsum_xy) : rate_sat(rsum);
    a4_r <= a3_r;
  end

  // stage 5: burn and elapsed, then write back
  logic [61:0] bm;
  logic [46:0] burn;
  logic [31:0] els;
  ent_t wb;
  assign bm = 62'(rate_r) * 62'(time_step);
  assign burn = 47'(bm >> FracBits);
  assign els = 32'(e4_r.el) + 32'(time_step);
  always_comb begin
    wb = e4_r;
    wb.fuel = (burn > 47'(e4_r.fuel)) ? 31'd0 : 31'(47'(e4_r.fuel) - burn);
    wb.el = els[31] ? 31'h7fffffff : els[30:0];
  end

  logic signed [31:0] lpz;
  assign lpz = in_pos_z[31] ? 32'sd0 : in_pos_z;

  always_ff @(posedge clk) begin
    if (cmd.wr_load)
      mem_ent[cmd.addr] <= '{px: in_pos_x, py: in_pos_y, pz: lpz[30:0], vx: in_vel_x,
                             vy: in_vel_y, vz: in_vel_z, fuel: in_fuel_load,
                             el: in_elapsed_load};
    else if (s4_r)
      mem_ent[a4_r] <= wb;
    if (cmd.wr_cmd) mem_cmd[cmd.addr] <= '{x: in_vel_x, y: in_vel_y, z: in_vel_z};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= '0;
      s1_r <= 1'b0;
      s2_r <= 1'b0;
      s3_r <= 1'b0;
      s4_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.wr_cmd) cmd_vld_r[cmd.addr] <= 1'b1;
      s1_r <= cmd.rd;
      s2_r <= s1_r && !cmd.out_read;
      s3_r <= s2_r;
      s4_r <= s3_r;
      out_valid <= cmd.out_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_read) begin
      out_index <= cmd.addr;
      out_pos_x <= rd_ent_r.px;
      out_pos_y <= rd_ent_r.py;
      out_pos_z <= rd_ent_r.pz;
      out_vel_x <= rd_ent_r.vx;
      out_vel_y <= rd_ent_r.vy;
      out_vel_z <= rd_ent_r.vz;
      out_fuel <= rd_ent_r.fuel;
      out_elapsed <= rd_ent_r.el;
    end
  end
endmodule

// File: hw/rtl/batch_vehicle_kinematics_step.sv
// Load and command transfers leave busy low. A read holds busy in its ST_READ state, and
// its result strobes on out_valid, registered from that state, once busy is low again.
// A step keeps busy high while it walks min(active_count, 64) entries (one entry per cycle
// through a five-stage read-modify-write pipeline, then drain); a new transfer is taken
// only once busy drops. The receiver cannot stall.
// Reset (synchronous, rst_n low) restores registers to defaults and clears command valids;
// vehicle entries stay undefined until loaded.
module batch_vehicle_kinematics_step (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_opcode,
  input  logic [5:0] in_agent_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [30:0] in_fuel_load,
  input  logic [30:0] in_elapsed_load,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic out_valid,
  output logic [5:0] out_index,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [30:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  output logic [30:0] out_fuel,
  output logic [30:0] out_elapsed
);
  import bvk_pkg::*;
  `include "batch_vehicle_kinematics_step_defines.svh"

  // shared batch registers
  logic [30:0] ts_r, mh_r, mv_r, idle_r, spd_r;
  logic signed [31:0] we_r, wn_r;
  logic [CntW-1:0] ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= 31'h10000;
      mh_r <= 31'h10000;
      mv_r <= 31'h10000;
      idle_r <= '0;
      spd_r <= '0;
      we_r <= '0;
      wn_r <= '0;
      ac_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_STEP: ts_r <= cfg_data[30:0];
        REG_MAX_H:     mh_r <= cfg_data[30:0];
        REG_MAX_V:     mv_r <= cfg_data[30:0];
        REG_IDLE:      idle_r <= cfg_data[30:0];
        REG_SPEED:     spd_r <= cfg_data[30:0];
        REG_WIND_E:    we_r <= cfg_data;
        REG_WIND_N:    wn_r <= cfg_data;
        default:       ac_r <= cfg_data[CntW-1:0];
      endcase
    end
  end

  bvk_cmd_t cmd;

  bvk_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_opcode, .in_agent_index,
    .active_count(ac_r), .busy, .cmd
  );

  bvk_datapath u_dp (
    .clk, .rst_n, .cmd,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_vel_x, .in_vel_y, .in_vel_z,
    .in_fuel_load, .in_elapsed_load,
    .time_step(ts_r), .max_step_horizontal(mh_r), .max_step_vertical(mv_r),
    .idle_burn_rate(idle_r), .speed_burn_rate(spd_r),
    .wind_east(we_r), .wind_north(wn_r),
    .out_valid, .out_index, .out_pos_x, .out_pos_y, .out_pos_z,
    .out_vel_x, .out_vel_y, .out_vel_z, .out_fuel, .out_elapsed
  );

  // a read transfer holds busy for the cycle that fetches its entry
  `BVK_ASSERT_NXT(a_read_busy, start && !busy && in_opcode == OP_READ, busy)
  // a result strobes only once the controller is back in idle
  `BVK_ASSERT_IMP(a_out_idle, out_valid, !busy)
endmodule

// File: dv/batch_vehicle_kinematics_step_test.sv
`timescale 1ns / 1ps

module batch_vehicle_kinematics_step_test;
  import bvk_pkg::*;

  localparam int WatchLimit = 3000;
  localparam int DrainCycles = 80;   // outlasts a full step walk of all 64 entries
  localparam int RandItems = 1950;
  localparam int NumPhases = 6;
  localparam longint SMax = 64'sd2147483647;
  localparam longint SMin = -64'sd2147483648;

  typedef struct {
    logic [5:0] idx;
    logic [31:0] px, py;
    logic [30:0] pz;
    logic [31:0] vx, vy, vz;
    logic [30:0] fuel, elapsed;
  } veh_state_t;

  typedef struct {
    logic [1:0] op;
    logic [5:0] idx;
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [30:0] fuel, elapsed;
    bit typed;
    veh_state_t want;
  } veh_op_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_opcode;
  logic [5:0] in_agent_index;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [31:0] in_vel_x, in_vel_y, in_vel_z;
  logic [30:0] in_fuel_load, in_elapsed_load;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic out_valid;
  logic [5:0] out_index;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [30:0] out_pos_z;
  logic signed [31:0] out_vel_x, out_vel_y, out_vel_z;
  logic [30:0] out_fuel, out_elapsed;

  batch_vehicle_kinematics_step i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the vehicle table and the shared batch registers.
  longint fleet_px[64], fleet_py[64], fleet_pz[64];
  longint fleet_vx[64], fleet_vy[64], fleet_vz[64];
  longint fleet_cx[64], fleet_cy[64], fleet_cz[64];
  longint fleet_fuel[64], fleet_elapsed[64];
  longint dt_q, slew_h, slew_v, burn_idle, burn_speed, wind_e, wind_n;
  int unsigned walk_len;

  veh_state_t readback_q[$];
  int errors = 0;
  int n_items = 0;
  int n_reads = 0;
  int n_steps = 0;
  int idle_cyc = 0;
  int idle_pct = 0;

  function automatic longint sat(longint v);
    return v > SMax ? SMax : (v < SMin ? SMin : v);
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  // Exact product, floored shift by the fraction width.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FracBits;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic advance_vehicle(int i);
    longint vx, vy, vz, z, spd, rate, fu, el;
    vx = sat(fleet_vx[i] + clamp_sym(fleet_cx[i] - fleet_vx[i], slew_h));
    vy = sat(fleet_vy[i] + clamp_sym(fleet_cy[i] - fleet_vy[i], slew_h));
    vz = sat(fleet_vz[i] + clamp_sym(fleet_cz[i] - fleet_vz[i], slew_v));
    fleet_px[i] = sat(fleet_px[i] + qmul(sat(vx + wind_e), dt_q));
    fleet_py[i] = sat(fleet_py[i] + qmul(sat(vy + wind_n), dt_q));
    z = sat(fleet_pz[i] + qmul(vz, dt_q));
    // ground contact: hold altitude at zero and kill the sink rate
    if (z < 0) begin
      z = 0;
      if (vz < 0) vz = 0;
    end
    fleet_pz[i] = z;
    fleet_vx[i] = vx;
    fleet_vy[i] = vy;
    fleet_vz[i] = vz;
    spd = mag(vx) + mag(vy) + mag(vz);
    if (spd > SMax) spd = SMax;
    rate = burn_idle + qmul(burn_speed, spd);
    if (rate > SMax) rate = SMax;
    fu = fleet_fuel[i] - qmul(rate, dt_q);
    fleet_fuel[i] = fu < 0 ? 0 : fu;
    el = fleet_elapsed[i] + dt_q;
    fleet_elapsed[i] = el > SMax ? SMax : el;
  endtask

  // Apply one accepted transfer to the shadow table; queue a readback.
  task automatic predict_fleet(veh_op_t t);
    veh_state_t r;
    int i;
    i = t.idx;
    case (t.op)
      OP_LOAD: begin
        fleet_px[i] = longint'($signed(t.px));
        fleet_py[i] = longint'($signed(t.py));
        fleet_pz[i] = $signed(t.pz) < 0 ? 0 : longint'($signed(t.pz));
        fleet_vx[i] = longint'($signed(t.vx));
        fleet_vy[i] = longint'($signed(t.vy));
        fleet_vz[i] = longint'($signed(t.vz));
        fleet_fuel[i] = longint'(t.fuel);
        fleet_elapsed[i] = longint'(t.elapsed);
      end
      OP_CMD: begin
        fleet_cx[i] = longint'($signed(t.vx));
        fleet_cy[i] = longint'($signed(t.vy));
        fleet_cz[i] = longint'($signed(t.vz));
      end
      OP_STEP: begin
        n_steps++;
        for (int k = 0; k < (walk_len > 64 ? 64 : walk_len); k++) advance_vehicle(k);
      end
      default: begin
        n_reads++;
        r.idx = t.idx;
        r.px = fleet_px[i][31:0];
        r.py = fleet_py[i][31:0];
        r.pz = fleet_pz[i][30:0];
        r.vx = fleet_vx[i][31:0];
        r.vy = fleet_vy[i][31:0];
        r.vz = fleet_vz[i][31:0];
        r.fuel = fleet_fuel[i][30:0];
        r.elapsed = fleet_elapsed[i][30:0];
        readback_q.push_back(t.typed ? t.want : r);
      end
    endcase
  endtask

  // Drive one transfer and hold it until the block takes it.
  task automatic issue(veh_op_t t);
    start <= 1'b1;
    in_opcode <= t.op;
    in_agent_index <= t.idx;
    in_pos_x <= t.px;
    in_pos_y <= t.py;
    in_pos_z <= t.pz;
    in_vel_x <= t.vx;
    in_vel_y <= t.vy;
    in_vel_z <= t.vz;
    in_fuel_load <= t.fuel;
    in_elapsed_load <= t.elapsed;
    do @(posedge clk); while (busy);
    n_items++;
    predict_fleet(t);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop start, wait out every readback, then let a step walk drain.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (readback_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] v[8]);
    for (int k = 0; k < 8; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(k);
      cfg_data <= v[k];
      case (3'(k))
        REG_TIME_STEP: dt_q = longint'(v[k][30:0]);
        REG_MAX_H:     slew_h = longint'(v[k][30:0]);
        REG_MAX_V:     slew_v = longint'(v[k][30:0]);
        REG_IDLE:      burn_idle = longint'(v[k][30:0]);
        REG_SPEED:     burn_speed = longint'(v[k][30:0]);
        REG_WIND_E:    wind_e = longint'($signed(v[k]));
        REG_WIND_N:    wind_n = longint'($signed(v[k]));
        default:       walk_len = v[k][6:0];
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic veh_op_t mk(logic [1:0] op, logic [5:0] idx, logic [31:0] px,
                                 logic [31:0] py, logic [31:0] pz, logic [31:0] vx,
                                 logic [31:0] vy, logic [31:0] vz, logic [30:0] fu,
                                 logic [30:0] el);
    veh_op_t t;
    t = '{op: op, idx: idx, px: px, py: py, pz: pz, vx: vx, vy: vy, vz: vz,
          fuel: fu, elapsed: el, typed: 1'b0, want: '{default: '0}};
    return t;
  endfunction

  // Mix of zero, both extremes, small signed values and full-range noise.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3, 4, 5: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic veh_op_t rand_op();
    int w;
    logic [1:0] op;
    w = $urandom_range(0, 99);
    op = w < 30 ? OP_READ : (w < 60 ? OP_CMD : (w < 75 ? OP_LOAD : OP_STEP));
    return mk(op, 6'($urandom_range(0, 63)), rand_q(), rand_q(), rand_q(), rand_q(),
              rand_q(), rand_q(), 31'(rand_q()), 31'(rand_q()));
  endfunction

  task automatic chk(string fld, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, e, a);
    end
  endtask

  // Compare every readback with the oldest prediction.
  always @(posedge clk) begin
    veh_state_t w;
    if (rst_n && out_valid) begin
      if (readback_q.size() == 0) begin
        errors++;
        $display("%0t: readback with none pending: expected nothing, actual index %0d",
                 $time, out_index);
      end else begin
        w = readback_q.pop_front();
        chk("index", 32'(w.idx), 32'(out_index));
        chk("pos_x", w.px, out_pos_x);
        chk("pos_y", w.py, out_pos_y);
        chk("pos_z", 32'(w.pz), 32'(out_pos_z));
        chk("vel_x", w.vx, out_vel_x);
        chk("vel_y", w.vy, out_vel_y);
        chk("vel_z", w.vz, out_vel_z);
        chk("fuel", 32'(w.fuel), 32'(out_fuel));
        chk("elapsed", 32'(w.elapsed), 32'(out_elapsed));
      end
    end
  end

  // Watchdog: count cycles in which nothing at all is transferred.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WatchLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  veh_op_t dir_tab[19];
  logic [31:0] regs[8];

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= OP_LOAD;
    in_agent_index <= '0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_pos_z <= '0;
    in_vel_x <= '0;
    in_vel_y <= '0;
    in_vel_z <= '0;
    in_fuel_load <= '0;
    in_elapsed_load <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_TIME_STEP;
    cfg_data <= '0;
    dt_q = 65536;
    slew_h = 65536;
    slew_v = 65536;
    burn_idle = 0;
    burn_speed = 0;
    wind_e = 0;
    wind_n = 0;
    walk_len = 0;
    for (int k = 0; k < 64; k++) begin
      fleet_cx[k] = 0;
      fleet_cy[k] = 0;
      fleet_cz[k] = 0;
    end

    // Reset defaults, nothing active: stores pass straight through, a step
    // changes nothing, and a negative altitude loads as ground level.
    dir_tab[0] = mk(OP_LOAD, 0, 32'h7fffffff, 32'h80000000, 32'hfffffffb, 1, 32'hffffffff,
                    0, 31'h7fffffff, 31'h7fffffff);
    dir_tab[1] = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[1].typed = 1'b1;
    dir_tab[1].want = '{6'd0, 32'h7fffffff, 32'h80000000, 31'd0, 32'd1, 32'hffffffff,
                        32'd0, 31'h7fffffff, 31'h7fffffff};
    dir_tab[2] = mk(OP_LOAD, 1, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                    32'h80000000, 0, 0);
    dir_tab[3] = mk(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[3].typed = 1'b1;
    dir_tab[3].want = '{6'd1, 32'd0, 32'd0, 31'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h80000000, 31'd0, 31'd0};
    dir_tab[4] = mk(OP_CMD, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0);
    dir_tab[5] = mk(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[6] = dir_tab[1];
    dir_tab[7] = mk(OP_LOAD, 63, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[8] = mk(OP_READ, 63, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[8].typed = 1'b1;
    dir_tab[8].want = '{6'd63, 32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 32'd0, 31'd0, 31'd0};
    // Two live entries under strong wind and full burn: ground contact,
    // fuel running dry, elapsed time pinned at its ceiling.
    dir_tab[9] = mk(OP_LOAD, 1, 0, 0, 32'h20000, 0, 0, 32'hfffd0000, 31'h10000,
                    31'h7fff0000);
    dir_tab[10] = mk(OP_CMD, 1, 0, 0, 0, 32'h7fffffff, 0, 32'h80000000, 0, 0);
    dir_tab[11] = mk(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[12] = mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[13] = mk(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[14] = dir_tab[11];
    dir_tab[15] = dir_tab[13];
    dir_tab[16] = mk(OP_CMD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[17] = dir_tab[11];
    dir_tab[18] = dir_tab[12];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      if (r == 9) begin
        settle();
        regs = '{32'h10000, 32'h7fffffff, 32'h10000, 32'h10000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'd2};
        write_regs(regs);
      end
      issue(dir_tab[r]);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: regs = '{32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0, 32'd64};
        // every register at its ceiling, walk length above the table size;
        // spare upper bits are set to show they are dropped
        1: regs = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffff7f};
        2: regs = '{32'h80000000, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'd1};
        default: regs = '{$urandom_range(0, 32'h40000) | ($urandom & 32'h80000000),
                          rand_q(), rand_q(), $urandom_range(0, 32'h30000),
                          $urandom_range(0, 32'h8000), rand_q(), rand_q(),
                          $urandom_range(0, 64)};
      endcase
      write_regs(regs);
      case (ph % 4)
        1: idle_pct = 52;
        3: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      // first pass loads the whole table so no entry is read or stepped unset
      if (ph == 0)
        for (int k = 0; k < 64; k++) begin
          veh_op_t t;
          t = rand_op();
          t.op = OP_LOAD;
          t.idx = 6'(k);
          issue(t);
        end
      for (int n = 0; n < RandItems / NumPhases; n++) begin
        if (n == 40) begin
          // hold off until every readback is back
          start <= 1'b0;
          @(posedge clk);
          while (readback_q.size() != 0) @(posedge clk);
        end
        issue(rand_op());
      end
    end

    settle();
    $display("Covered %0d transfers (%0d steps, %0d readbacks) over %0d register settings",
             n_items, n_steps, n_reads, NumPhases + 2);
    $display("with idle-free, heavy-idle and light-idle sender traffic.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
